### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define PRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the next edge
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/prp_pkg.sv
package prp_pkg;

    localparam int CordicStepsDef = 16;
    localparam int AtanLen        = 24;
    localparam int StepW          = 5;
    localparam int CfgIdxW        = 2;
    localparam int CfgDataW       = 24;
    localparam int DistW          = 23;
    localparam int CountW         = 24;
    localparam int CsW            = 34;
    localparam int NumW           = 36;

    localparam logic [CfgIdxW-1:0] CfgMaskDist = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDetDist  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgDetHalf  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgTarget   = 2'd3;

    localparam logic signed [CsW-1:0] GainQ30 = 34'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_DIVX,
        S_DIVY,
        S_MUL,
        S_ADD,
        S_CHECK,
        S_OUT
    } t_state;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [StepW-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### hdl/prp_req_if.sv
interface prp_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth_frac;
    logic [15:0] angle;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;

    modport source (output valid, depth_frac, angle, src_x, src_y, input ready);
    modport sink   (input valid, depth_frac, angle, src_x, src_y, output ready);
endinterface

### hdl/prp_rsp_if.sv
interface prp_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [23:0] orig_x;
    logic signed [23:0] orig_y;
    logic signed [23:0] mask_x;
    logic signed [23:0] mask_y;
    logic signed [23:0] det_x;
    logic signed [23:0] det_y;
    logic        last;

    modport source (output valid, dir_x, dir_y, orig_x, orig_y, mask_x, mask_y,
                    det_x, det_y, last, input ready);
    modport sink   (input valid, dir_x, dir_y, orig_x, orig_y, mask_x, mask_y,
                    det_x, det_y, last, output ready);
endinterface

### hdl/photon_ray_plane_projection_top.sv
// Channel   Dir  Contents
// i_req     in   depth_frac, angle, src_x, src_y
// o_rsp     out  dir_x, dir_y, orig_x, orig_y, mask_x, mask_y, det_x, det_y, last
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// One request at a time: accept in idle, CORDIC rotation, then the X and Y slopes in
// turn on the shared bit-serial divider, four products on the shared multiplier, each
// a multiply and an add state, then a check state and an output state that waits.
// Requests outside the detector skip the output cycle. Dropped requests are accepted in idle and start no work.
// Ready is high only when idle; the result is held until taken.
// Synchronous active-low reset clears the sequencer, count and configuration registers.
`include "assert_macros.svh"

module photon_ray_plane_projection_top #(
    parameter int CORDIC_STEPS = prp_pkg::CordicStepsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [prp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [prp_pkg::CfgDataW-1:0] i_cfg_data,
    prp_req_if.sink                      i_req,
    prp_rsp_if.source                    o_rsp
);
    import prp_pkg::*;

    t_state r_state, n_state;

    logic [DistW-1:0]  r_mask_dist, r_det_dist, r_half;
    logic [CountW-1:0] r_target, r_count;

    logic [15:0]        r_d;
    logic signed [23:0] r_sx, r_sy;
    logic signed [31:0] r_dx, r_dy;
    logic [1:0]         r_sel;
    logic signed [55:0] r_prod;
    logic signed [40:0] r_px, r_py, r_mx, r_my;
    logic               r_last;

    logic acc, go, in_det;
    logic cor_start, cor_done, div_start, div_done;
    logic signed [CsW-1:0]  cos_v, sin_v;
    logic signed [NumW-1:0] div_num;
    logic signed [31:0]     quot, dsel;
    logic [DistW-1:0]       dist_sel;
    logic signed [23:0]     src_sel;
    logic signed [55:0]     n_prod;
    logic signed [40:0]     n_hit, h41;
    logic [CountW-1:0]      cnt_inc;

    prp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (i_req.angle),
        .o_done  (cor_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    prp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        acc      = i_req.valid && i_req.ready;
        go       = (i_req.depth_frac != 16'h0) && (r_count < r_target);
        h41      = signed'({18'h0, r_half});
        in_det   = (r_px <= h41) && (r_px >= -h41) && (r_py <= h41) && (r_py >= -h41);
        cnt_inc  = r_count + 1'b1;
        dsel     = r_sel[0] ? r_dy : r_dx;
        src_sel  = r_sel[0] ? r_sy : r_sx;
        dist_sel = r_sel[1] ? r_mask_dist : r_det_dist;
        n_prod   = dsel * signed'({1'b0, dist_sel});
        n_hit    = {{17{src_sel[23]}}, src_sel} + {r_prod[55], r_prod[55:16]};
        div_num  = (r_state == S_ROT) ? NumW'(cos_v) <<< 2 : NumW'(sin_v) <<< 2;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc && go) n_state = S_ROT;
            S_ROT:   if (cor_done) n_state = S_DIVX;
            S_DIVX:  if (div_done) n_state = S_DIVY;
            S_DIVY:  if (div_done) n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   if (r_sel == 2'd3) n_state = S_CHECK; else n_state = S_MUL;
            S_CHECK: if (in_det) n_state = S_OUT; else n_state = S_IDLE;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        o_rsp.valid = (r_state == S_OUT);
        cor_start   = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE:  cor_start = 1'b0;
            S_ROT:   div_start = cor_done;
            S_DIVX:  div_start = div_done;
            default: div_start = 1'b0;
        endcase
        if (r_state == S_IDLE && n_state == S_ROT) begin
            cor_start = 1'b1;
        end
    end

    // rotation takes the angle straight from the request on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask_dist <= '0;
            r_det_dist  <= '0;
            r_half      <= '0;
            r_target    <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMaskDist: r_mask_dist <= i_cfg_data[DistW-1:0];
                    CfgDetDist:  r_det_dist  <= i_cfg_data[DistW-1:0];
                    CfgDetHalf:  r_half      <= i_cfg_data[DistW-1:0];
                    CfgTarget:   r_target    <= i_cfg_data[CountW-1:0];
                    default:     r_target    <= r_target;
                endcase
            end
            if (r_state == S_CHECK && in_det) begin
                r_count <= cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_d     <= i_req.depth_frac;
            r_sx    <= i_req.src_x;
            r_sy    <= i_req.src_y;
            r_sel   <= 2'd0;
        end
        if (r_state == S_DIVX && div_done) r_dx <= quot;
        if (r_state == S_DIVY && div_done) r_dy <= quot;
        if (r_state == S_MUL) r_prod <= n_prod;
        if (r_state == S_ADD) begin
            r_sel <= r_sel + 1'b1;
            case (r_sel)
                2'd0:    r_px <= n_hit;
                2'd1:    r_py <= n_hit;
                2'd2:    r_mx <= n_hit;
                default: r_my <= n_hit;
            endcase
        end
        if (r_state == S_CHECK) r_last <= (cnt_inc == r_target);
    end

    function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
        logic signed [23:0] s;
        if (v > 41'sd8388607) s = 24'sh7FFFFF;
        else if (v < -41'sd8388608) s = 24'sh800000;
        else s = v[23:0];
        return s;
    endfunction

    always_comb begin
        o_rsp.dir_x  = r_dx;
        o_rsp.dir_y  = r_dy;
        o_rsp.orig_x = r_sx;
        o_rsp.orig_y = r_sy;
        o_rsp.mask_x = sat24(r_mx);
        o_rsp.mask_y = sat24(r_my);
        o_rsp.det_x  = r_px[23:0];
        o_rsp.det_y  = r_py[23:0];
        o_rsp.last   = r_last;
    end

    `PRP_ASSERT_NEXT(a_count_only_on_check, r_state != S_CHECK, $stable(r_count), "count moved")
    `PRP_ASSERT_NOW(a_cordic_done_in_rot, cor_done, r_state == S_ROT, "stray cordic done")
    `PRP_ASSERT_NOW(a_div_done_in_div, div_done, r_state == S_DIVX || r_state == S_DIVY, "stray div done")

endmodule

### hdl/prp_cordic.sv
module prp_cordic #(
    parameter int STEPS = prp_pkg::CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_angle,
    output logic        o_done,
    output logic signed [prp_pkg::CsW-1:0] o_cos,
    output logic signed [prp_pkg::CsW-1:0] o_sin
);
    import prp_pkg::*;

    localparam int LastStep = STEPS - 1;

    logic                    r_busy, r_done;
    logic [StepW-1:0]        r_step;
    logic [1:0]              r_q;
    logic signed [CsW-1:0]   r_x, r_y;
    logic signed [32:0]      r_r;

    logic [15:0]             a_rnd;
    logic [1:0]              q0;
    logic [31:0]             rr;
    logic signed [CsW-1:0]   dx, dy;
    logic signed [32:0]      at;

    always_comb begin
        a_rnd = i_angle + 16'h2000;
        q0    = a_rnd[15:14];
        rr    = {i_angle, 16'h0} - {q0, 30'h0};
        dx    = r_y >>> r_step;
        dy    = r_x >>> r_step;
        at    = signed'({1'b0, atan_turn(r_step)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LastStep[StepW-1:0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= q0;
            r_x <= GainQ30;
            r_y <= '0;
            r_r <= signed'({rr[31], rr});
        end else if (r_busy) begin
            if (!r_r[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_r <= r_r - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_r <= r_r + at;
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0:    begin o_cos = r_x;  o_sin = r_y;  end
            2'd1:    begin o_cos = -r_y; o_sin = r_x;  end
            2'd2:    begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y;  o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

endmodule

### hdl/prp_div.sv
module prp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic signed [prp_pkg::NumW-1:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic signed [31:0] o_quot
);
    import prp_pkg::*;

    localparam int MagW = NumW - 1;

    logic              r_busy, r_done, r_neg;
    logic [5:0]        r_cnt;
    logic [MagW-1:0]   r_mag, r_q;
    logic [15:0]       r_rem, r_den;

    logic [NumW-1:0]   abs_num;
    logic [16:0]       trial;
    logic              fits;

    always_comb begin
        abs_num = i_num[NumW-1] ? -i_num : i_num;
        trial   = {r_rem, r_mag[MagW-1]};
        fits    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'(MagW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NumW-1];
            r_mag <= abs_num[MagW-1:0];
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[MagW-2:0], 1'b0};
            r_rem <= fits ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_q   <= {r_q[MagW-2:0], fits};
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > MagW'(33'h80000000)) ? 32'sh80000000 : -signed'(r_q[31:0]);
        end else begin
            o_quot = (r_q > MagW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : signed'(r_q[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

### tb/photon_ray_plane_projection_top_test.sv
module photon_ray_plane_projection_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prp_pkg::*;

    localparam int  NUM_STEPS   = 16;
    localparam int  DRAIN_WAIT  = 160;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam longint DIST_MAX = 64'd8388607;
    localparam longint TGT_MAX  = 64'd16777215;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [23:0] orig_x;
        logic signed [23:0] orig_y;
        logic signed [23:0] mask_x;
        logic signed [23:0] mask_y;
        logic signed [23:0] det_x;
        logic signed [23:0] det_y;
        logic               last;
    } photon_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    prp_req_if req();
    prp_rsp_if rsp();

    photon_ray_plane_projection_top dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req),
        .o_rsp     (rsp)
    );

    longint  mask_dist, det_dist, det_half, target, photon_count;
    photon_t photon_q[$];
    int      fail_count;
    int      send_idle_pct, recv_idle_pct;
    int      recv_hold;
    longint  cycle_count;
    longint  atan_tbl[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("photon_ray_plane_projection_top_test: FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus a counted long hold-off
    always @(posedge clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void rotate_angle(input logic [15:0] a, output longint c,
                                         output longint s);
        logic [31:0] p;
        logic [31:0] rr;
        logic [1:0]  q;
        longint      r, x, y, dx, dy;
        p  = {a, 16'h0};
        q  = 2'((p + 32'h20000000) >> 30);
        rr = p - {q, 30'b0};
        r  = longint'($signed(rr));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < NUM_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x -= dx; y += dy; r -= atan_tbl[i];
            end else begin
                x += dx; y -= dy; r += atan_tbl[i];
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint slope_of(input longint c, input longint d);
        longint n, qt;
        n  = c * 4;
        qt = (n < 0 ? -n : n) / d;
        if (n < 0)
            return (qt > 64'h80000000) ? -64'sh80000000 : -qt;
        return (qt > 64'h7FFFFFFF) ? 64'sh7FFFFFFF : qt;
    endfunction

    function automatic longint sat_pos(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // expected photon for one accepted request; updates the running count
    function automatic void predict_photon(input logic [15:0] d, input logic [15:0] a,
                                           input logic signed [23:0] sx,
                                           input logic signed [23:0] sy);
        longint  c, s, dx, dy, px, py;
        photon_t ph;
        if (photon_count >= target || d == 0)
            return;
        rotate_angle(a, c, s);
        dx = slope_of(c, longint'(d));
        dy = slope_of(s, longint'(d));
        px = longint'(sx) + ((dx * det_dist) >>> 16);
        py = longint'(sy) + ((dy * det_dist) >>> 16);
        if (px > det_half || px < -det_half || py > det_half || py < -det_half)
            return;
        photon_count = (photon_count + 1) & 64'hFFFFFF;
        ph.dir_x  = dx[31:0];
        ph.dir_y  = dy[31:0];
        ph.orig_x = sx;
        ph.orig_y = sy;
        ph.mask_x = 24'(sat_pos(longint'(sx) + ((dx * mask_dist) >>> 16)));
        ph.mask_y = 24'(sat_pos(longint'(sy) + ((dy * mask_dist) >>> 16)));
        ph.det_x  = px[23:0];
        ph.det_y  = py[23:0];
        ph.last   = (photon_count == target);
        photon_q.push_back(ph);
    endfunction

    always @(posedge clk) begin
        photon_t ph;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (photon_q.size() == 0) begin
                $error("unexpected photon");
                fail_count++;
            end else begin
                ph = photon_q.pop_front();
                if (rsp.dir_x !== ph.dir_x) begin
                    $error("dir_x exp %0d got %0d", ph.dir_x, rsp.dir_x); fail_count++;
                end
                if (rsp.dir_y !== ph.dir_y) begin
                    $error("dir_y exp %0d got %0d", ph.dir_y, rsp.dir_y); fail_count++;
                end
                if (rsp.orig_x !== ph.orig_x) begin
                    $error("orig_x exp %0d got %0d", ph.orig_x, rsp.orig_x); fail_count++;
                end
                if (rsp.orig_y !== ph.orig_y) begin
                    $error("orig_y exp %0d got %0d", ph.orig_y, rsp.orig_y); fail_count++;
                end
                if (rsp.mask_x !== ph.mask_x) begin
                    $error("mask_x exp %0d got %0d", ph.mask_x, rsp.mask_x); fail_count++;
                end
                if (rsp.mask_y !== ph.mask_y) begin
                    $error("mask_y exp %0d got %0d", ph.mask_y, rsp.mask_y); fail_count++;
                end
                if (rsp.det_x !== ph.det_x) begin
                    $error("det_x exp %0d got %0d", ph.det_x, rsp.det_x); fail_count++;
                end
                if (rsp.det_y !== ph.det_y) begin
                    $error("det_y exp %0d got %0d", ph.det_y, rsp.det_y); fail_count++;
                end
                if (rsp.last !== ph.last) begin
                    $error("last exp %0b got %0b", ph.last, rsp.last); fail_count++;
                end
            end
        end
    end

    task automatic send_photon(input logic [15:0] d, input logic [15:0] a,
                               input logic signed [23:0] sx, input logic signed [23:0] sy);
        if ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req.valid      <= 1'b1;
        req.depth_frac <= d;
        req.angle      <= a;
        req.src_x      <= sx;
        req.src_y      <= sy;
        do @(posedge clk); while (!(req.valid && req.ready));
        predict_photon(d, a, sx, sy);
    endtask

    task automatic drain_photons();
        req.valid <= 1'b0;
        while (photon_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_regs(input longint md, input longint dd, input longint dh,
                              input longint tg);
        drain_photons();
        cfg_we <= 1'b1; cfg_idx <= CfgMaskDist; cfg_data <= 24'(md);
        @(posedge clk);
        cfg_idx <= CfgDetDist; cfg_data <= 24'(dd);
        @(posedge clk);
        cfg_idx <= CfgDetHalf; cfg_data <= 24'(dh);
        @(posedge clk);
        cfg_idx <= CfgTarget; cfg_data <= 24'(tg);
        @(posedge clk);
        cfg_we <= 1'b0;
        mask_dist = md & 64'h7FFFFF; det_dist = dd & 64'h7FFFFF;
        det_half = dh & 64'h7FFFFF; target = tg & 64'hFFFFFF;
    endtask

    task automatic test_angles();
        logic [15:0] angs[7] = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152,
                                 16'd65535, 16'd12345};
        write_regs(2560, 5120, DIST_MAX, TGT_MAX);
        foreach (angs[i])
            send_photon(16'hFFFF, angs[i], 24'sd0, 24'sd0);
        send_photon(16'd0, 16'd0, 24'sd0, 24'sd0);
        send_photon(16'd32768, 16'd40000, 24'sh7FFFFF, 24'sh800000);
        send_photon(16'd1000, 16'd20000, 24'sh800000, 24'sh7FFFFF);
    endtask

    task automatic test_saturation();
        write_regs(DIST_MAX, 0, DIST_MAX, TGT_MAX);
        send_photon(16'd1, 16'd0, 24'sd0, 24'sd0);
        send_photon(16'd1, 16'd32768, 24'sh7FFFFF, 24'sh800000);
        send_photon(16'd2, 16'd8192, 24'sh800000, 24'sh7FFFFF);
        send_photon(16'd3, 16'd57000, 24'sd100, -24'sd100);
    endtask

    task automatic test_detector_edge();
        write_regs(2560, 5120, 0, TGT_MAX);
        send_photon(16'hFFFF, 16'd0, 24'sd0, 24'sd0);
        write_regs(0, 0, 0, TGT_MAX);
        send_photon(16'd500, 16'd100, 24'sd0, 24'sd0);
        send_photon(16'd500, 16'd100, 24'sd1, 24'sd0);
    endtask

    task automatic test_target();
        write_regs(256, 512, DIST_MAX, 0);
        send_photon(16'hFFFF, 16'd0, 24'sd0, 24'sd0);
        write_regs(256, 512, DIST_MAX, photon_count + 2);
        repeat (4) send_photon(16'hF000, 16'($urandom), 24'sd10, 24'sd20);
        write_regs(256, 512, DIST_MAX, photon_count - 1);
        send_photon(16'hF000, 16'd5, 24'sd0, 24'sd0);
        write_regs(256, 512, DIST_MAX, photon_count + 1);
        send_photon(16'hF000, 16'd5, 24'sd0, 24'sd0);
    endtask

    task automatic test_random(input int n_items, input int s_idle, input int r_idle,
                               input bit hold);
        logic [15:0]        d;
        logic signed [23:0] sx, sy;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < n_items; k++) begin
            if (k % 60 == 0)
                write_regs($urandom_range(0, 25600), $urandom_range(0, 25600),
                           ($urandom_range(9) == 0) ? $urandom_range(0, 4096)
                                                    : $urandom_range(1 << 20, DIST_MAX),
                           ($urandom_range(4) == 0) ? photon_count + $urandom_range(1, 20)
                                                    : TGT_MAX);
            if (hold && k == 30)
                recv_hold = 3000;
            case ($urandom_range(9))
                0:       d = 16'($urandom);
                1:       d = 16'($urandom_range(0, 16));
                default: d = 16'($urandom_range(4096, 65535));
            endcase
            if ($urandom_range(3) == 0) begin
                sx = 24'($urandom); sy = 24'($urandom);
            end else begin
                sx = 24'($signed($urandom_range(0, 200000)) - 100000);
                sy = 24'($signed($urandom_range(0, 200000)) - 100000);
            end
            send_photon(d, 16'($urandom), sx, sy);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        req.valid = 1'b0; req.depth_frac = '0; req.angle = '0;
        req.src_x = '0; req.src_y = '0;
        rsp.ready = 1'b0;
        recv_hold = 0; cycle_count = 0; fail_count = 0;
        send_idle_pct = 15; recv_idle_pct = 50;
        mask_dist = 0; det_dist = 0; det_half = 0; target = 0; photon_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_angles();
        test_saturation();
        test_detector_edge();
        test_target();
        test_random(470, 15, 50, 1'b0);
        test_random(470, 50, 15, 1'b0);
        test_random(470, 0, 0, 1'b1);
        drain_photons();
        if (fail_count == 0)
            $display("photon_ray_plane_projection_top_test: PASS");
        else
            $display("photon_ray_plane_projection_top_test: FAIL");
        $finish;
    end
endmodule
